@@ src/assert_macros.svh @@
// Assertion macros shared by the range table RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/ismq_pkg.sv @@
// Package for the interval set merge query block: sizes, cell commands and link types.
// Used by ismq_cell and interval_set_merge_query_core; depends on nothing else.
package ismq_pkg;

  localparam int MAX_RANGES = 64;
  localparam int VALUE_BITS = 63;
  localparam int FIELD_W = 63;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int TOT_W = 64;
  localparam logic [FIELD_W-1:0] COVERED_MAX = '1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLASSIFY,
    OP_INSERT,
    OP_SHIFT,
    OP_LOAD
  } op_t;

  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_HEAD,
    PICK_NEXT
  } pick_t;

  typedef struct packed {
    op_t                   op;
    pick_t                 pick;
    logic [VALUE_BITS-1:0] key_lo;
    logic [VALUE_BITS-1:0] key_hi;
    logic [CNT_W-1:0]      count;
  } cell_ctl_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    logic                  below;
    logic                  merge;
    logic                  pos;
  } cell_link_t;

  typedef struct packed {
    logic                  hit;
    logic                  nm;
    logic [VALUE_BITS-1:0] pick_lo;
    logic [VALUE_BITS-1:0] pick_hi;
  } cell_stat_t;

  function automatic logic [TOT_W-1:0] span_len(input logic [VALUE_BITS-1:0] lo,
                                                input logic [VALUE_BITS-1:0] hi);
    return TOT_W'(hi - lo) + TOT_W'(1);
  endfunction

endpackage

@@ src/ismq_cell.sv @@
// One cell of the range table: holds one stored range and its classification flags.
// Depends on ismq_pkg; instantiated in a row by interval_set_merge_query_core.
module ismq_cell import ismq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  cell_link_t       prev,
  input  cell_link_t       next,
  output cell_link_t       link,
  output cell_stat_t       stat
);

  logic [VALUE_BITS-1:0] lo;
  logic [VALUE_BITS-1:0] hi;
  logic below;
  logic merge;
  logic hit;
  logic pos;
  logic after;
  logic occ;
  logic below_c;
  logic above_c;
  logic hit_c;
  logic picked;

  always_comb begin
    pos     = !below && prev.below;
    after   = !below && !pos;
    occ     = CNT_W'(idx) < ctl.count;
    below_c = ({1'b0, hi} + (VALUE_BITS + 1)'(1)) < {1'b0, ctl.key_lo};
    above_c = ({1'b0, ctl.key_hi} + (VALUE_BITS + 1)'(1)) < {1'b0, lo};
    hit_c   = occ && (lo <= ctl.key_lo) && (ctl.key_hi <= hi);
    picked  = ((ctl.pick == PICK_HEAD) && pos) || ((ctl.pick == PICK_NEXT) && prev.pos);
  end

  assign link = '{lo: lo, hi: hi, below: below, merge: merge, pos: pos};
  assign stat = '{hit: hit, nm: prev.pos && merge,
                  pick_lo: picked ? lo : '0, pick_hi: picked ? hi : '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      below <= 1'b0;
      merge <= 1'b0;
      hit   <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_CLASSIFY: begin
          below <= occ && below_c;
          merge <= occ && !below_c && !above_c;
          hit   <= hit_c;
        end
        OP_SHIFT: begin
          if (after) begin
            merge <= next.merge;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INSERT: begin
        if (pos) begin
          lo <= ctl.key_lo;
          hi <= ctl.key_hi;
        end else if (after) begin
          lo <= prev.lo;
          hi <= prev.hi;
        end
      end
      OP_SHIFT: begin
        if (after) begin
          lo <= next.lo;
          hi <= next.hi;
        end
      end
      OP_LOAD: begin
        if (pos) begin
          lo <= ctl.key_lo;
          hi <= ctl.key_hi;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/interval_set_merge_query_core.sv @@
// Top level of the interval set merge query block: sequencer, totals and the cell row.
// Depends on ismq_pkg, ismq_cell and assert_macros.svh.
//
// Usage: the request channel (req_valid, req_ready) carries one item with cmd, range_low,
// range_high and probe. A cmd of 0 inserts the closed range into a sorted, merged table of
// up to 64 ranges; a cmd of 1 asks whether probe lies in a stored range. Every item yields
// one response on (rsp_valid, rsp_ready) with hit, covered_total and status.
// Sequence: a query, an insert that touches no stored range and a dropped full-table insert
// pass through the classify, decide and finish states; the response is registered in finish.
// An insert that merges stored ranges also steps through merge, folding in one stored range
// per step as the row of cells shifts one place, then through write before finish. An insert
// with range_low above range_high goes straight from idle to finish.
// One item is in work at a time; req_ready is high whenever the sequencer is free, even
// while an earlier response still waits in the output register. If the receiver stalls,
// the finished result waits until the output register empties.
// Reset empties the table and clears the covered total; no clearing pass is needed.
module interval_set_merge_query_core import ismq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               cmd,
  input  logic [FIELD_W-1:0] range_low,
  input  logic [FIELD_W-1:0] range_high,
  input  logic [FIELD_W-1:0] probe,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               hit,
  output logic [FIELD_W-1:0] covered_total,
  output logic [1:0]         status
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DECIDE,
    ST_MERGE,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  state_t                state;
  logic                  is_query;
  logic [VALUE_BITS-1:0] key_lo;
  logic [VALUE_BITS-1:0] key_hi;
  logic [VALUE_BITS-1:0] pick_lo;
  logic [VALUE_BITS-1:0] pick_hi;
  logic                  pick_valid;
  logic [CNT_W-1:0]      count;
  logic [TOT_W-1:0]      total;
  logic                  res_hit;
  status_t               res_status;

  logic [VALUE_BITS-1:0] in_lo;
  logic [VALUE_BITS-1:0] in_hi;
  logic [VALUE_BITS-1:0] in_probe;
  logic                  full;
  logic                  any_merge;
  logic                  any_hit;
  logic                  next_merge;
  logic [VALUE_BITS-1:0] pick_or_lo;
  logic [VALUE_BITS-1:0] pick_or_hi;
  logic [MAX_RANGES-1:0] pos_vec;
  cell_ctl_t             ctl;
  cell_link_t            link [MAX_RANGES+2];
  cell_stat_t            stat [MAX_RANGES];

  assign req_ready = (state == ST_IDLE);
  assign in_lo     = range_low[VALUE_BITS-1:0];
  assign in_hi     = range_high[VALUE_BITS-1:0];
  assign in_probe  = probe[VALUE_BITS-1:0];
  assign full      = (count == CNT_W'(MAX_RANGES));

  assign link[0] = '{lo: '0, hi: '0, below: 1'b1, merge: 1'b0, pos: 1'b0};
  assign link[MAX_RANGES+1] = '{lo: '0, hi: '0, below: 1'b0, merge: 1'b0, pos: 1'b0};

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    ismq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .idx  (IDX_W'(k)),
      .prev (link[k]),
      .next (link[k+2]),
      .link (link[k+1]),
      .stat (stat[k])
    );
  end

  always_comb begin
    any_merge  = 1'b0;
    any_hit    = 1'b0;
    next_merge = 1'b0;
    pick_or_lo = '0;
    pick_or_hi = '0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      any_merge  = any_merge | link[k+1].merge;
      any_hit    = any_hit | stat[k].hit;
      next_merge = next_merge | stat[k].nm;
      pick_or_lo = pick_or_lo | stat[k].pick_lo;
      pick_or_hi = pick_or_hi | stat[k].pick_hi;
      pos_vec[k] = link[k+1].pos;
    end
  end

  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.pick   = PICK_NONE;
    ctl.key_lo = key_lo;
    ctl.key_hi = key_hi;
    ctl.count  = count;
    unique case (state)
      ST_CLASSIFY: begin
        ctl.op = OP_CLASSIFY;
      end
      ST_DECIDE: begin
        if (!is_query) begin
          if (any_merge) begin
            ctl.pick = PICK_HEAD;
          end else if (!full) begin
            ctl.op = OP_INSERT;
          end
        end
      end
      ST_MERGE: begin
        if (next_merge) begin
          ctl.op   = OP_SHIFT;
          ctl.pick = PICK_NEXT;
        end
      end
      ST_WRITE: begin
        ctl.op = OP_LOAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      total      <= '0;
      pick_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            is_query   <= cmd;
            key_lo     <= cmd ? in_probe : in_lo;
            key_hi     <= cmd ? in_probe : in_hi;
            res_hit    <= 1'b0;
            if (!cmd && (in_lo > in_hi)) begin
              res_status <= STAT_EMPTY;
              state      <= ST_FINISH;
            end else begin
              res_status <= STAT_OK;
              state      <= ST_CLASSIFY;
            end
          end
        end
        ST_CLASSIFY: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (is_query) begin
            res_hit <= any_hit;
            state   <= ST_FINISH;
          end else if (!any_merge) begin
            if (full) begin
              res_status <= STAT_FULL;
            end else begin
              count <= count + CNT_W'(1);
              total <= total + span_len(key_lo, key_hi);
            end
            state <= ST_FINISH;
          end else begin
            pick_lo    <= pick_or_lo;
            pick_hi    <= pick_or_hi;
            pick_valid <= 1'b1;
            state      <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (pick_valid) begin
            key_lo <= (pick_lo < key_lo) ? pick_lo : key_lo;
            key_hi <= (pick_hi > key_hi) ? pick_hi : key_hi;
            total  <= total - span_len(pick_lo, pick_hi);
          end
          if (next_merge) begin
            pick_lo    <= pick_or_lo;
            pick_hi    <= pick_or_hi;
            pick_valid <= 1'b1;
            count      <= count - CNT_W'(1);
          end else begin
            pick_valid <= 1'b0;
            state      <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          total <= total + span_len(key_lo, key_hi);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid     <= 1'b1;
            hit           <= res_hit;
            status        <= res_status;
            covered_total <= (total > TOT_W'(COVERED_MAX)) ? COVERED_MAX
                                                           : total[FIELD_W-1:0];
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNT_W'(MAX_RANGES), "Range count exceeds table size.")
  `ASSERT_ALWAYS(a_pos_onehot, clk, rst, $onehot0(pos_vec), "More than one insertion point in the row.")
  `ASSERT_IMPLY(a_merge_count, clk, rst, (state == ST_MERGE) && next_merge, count > CNT_W'(1), "Merge step with fewer than two stored ranges.")
  `ASSERT_IMPLY(a_full_drop, clk, rst, (state == ST_FINISH) && (res_status == STAT_FULL), full, "Full-table drop while the table has room.")

endmodule

@@ tb/sv/tb_interval_set_merge_query_core.sv @@
// Testbench for interval_set_merge_query_core: directed and random inserts and point queries,
// each answer checked against a behavioral model of the merged range table kept here.
// Depends on ismq_pkg and the core RTL.
module tb_interval_set_merge_query_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ismq_pkg::*;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [FIELD_W-1:0] VMAX = '1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] pt;
  } req_item_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] total;
    logic [1:0]         status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic               cmd = CMD_INSERT;
  logic [FIELD_W-1:0] range_low = '0;
  logic [FIELD_W-1:0] range_high = '0;
  logic [FIELD_W-1:0] probe = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic               hit;
  logic [FIELD_W-1:0] covered_total;
  logic [1:0]         status;

  req_item_t          req_q[$];
  answer_t            answer_q[$];
  logic [FIELD_W-1:0] end_pool[$];
  int                 items_total;
  int                 items_sent = 0;
  int                 fail_count = 0;
  wire                calm = (items_sent >= 350) && (items_sent < 520);

  // Model of the stored table: sorted, disjoint, non-touching ranges.
  logic [FIELD_W-1:0] span_lo[MAX_RANGES];
  logic [FIELD_W-1:0] span_hi[MAX_RANGES];
  int                 span_n = 0;
  logic [FIELD_W-1:0] union_size = '0;

  interval_set_merge_query_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .cmd          (cmd),
    .range_low    (range_low),
    .range_high   (range_high),
    .probe        (probe),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .hit          (hit),
    .covered_total(covered_total),
    .status       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [1:0] merge_range(input logic [FIELD_W-1:0] lo_in,
                                             input logic [FIELD_W-1:0] hi_in);
    logic [63:0]        lo, hi, elo, ehi, acc, len;
    logic [FIELD_W-1:0] nlo[MAX_RANGES];
    logic [FIELD_W-1:0] nhi[MAX_RANGES];
    int                 n;
    bit                 placed;
    lo = {1'b0, lo_in};
    hi = {1'b0, hi_in};
    n = 0;
    placed = 1'b0;
    if (lo > hi) return ST_EMPTY;
    for (int k = 0; k < span_n; k++) begin
      elo = {1'b0, span_lo[k]};
      ehi = {1'b0, span_hi[k]};
      if (ehi + 64'd1 < lo) begin
        nlo[n] = elo[FIELD_W-1:0];
        nhi[n] = ehi[FIELD_W-1:0];
        n++;
      end else if (hi + 64'd1 < elo) begin
        if (!placed) begin
          if (n >= MAX_RANGES) return ST_FULL;
          nlo[n] = lo[FIELD_W-1:0];
          nhi[n] = hi[FIELD_W-1:0];
          n++;
          placed = 1'b1;
        end
        if (n >= MAX_RANGES) return ST_FULL;
        nlo[n] = elo[FIELD_W-1:0];
        nhi[n] = ehi[FIELD_W-1:0];
        n++;
      end else begin
        if (elo < lo) lo = elo;
        if (ehi > hi) hi = ehi;
      end
    end
    if (!placed) begin
      if (n >= MAX_RANGES) return ST_FULL;
      nlo[n] = lo[FIELD_W-1:0];
      nhi[n] = hi[FIELD_W-1:0];
      n++;
    end
    for (int k = 0; k < n; k++) begin
      span_lo[k] = nlo[k];
      span_hi[k] = nhi[k];
    end
    span_n = n;
    acc = '0;
    for (int k = 0; k < span_n; k++) begin
      len = {1'b0, span_hi[k]} - {1'b0, span_lo[k]} + 64'd1;
      if (len > {1'b0, COVERED_MAX} - acc) begin
        acc = {1'b0, COVERED_MAX};
        break;
      end
      acc += len;
    end
    union_size = acc[FIELD_W-1:0];
    return ST_OK;
  endfunction

  function automatic logic covers(input logic [FIELD_W-1:0] p);
    for (int k = 0; k < span_n; k++) begin
      if (p >= span_lo[k] && p <= span_hi[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [FIELD_W-1:0] rnd_value();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [FIELD_W-1:0] pick_end();
    if (end_pool.size() == 0) return rnd_value();
    return end_pool[$urandom_range(0, end_pool.size() - 1)];
  endfunction

  function automatic void add_insert(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
    req_item_t it;
    it.cmd = CMD_INSERT;
    it.lo = lo;
    it.hi = hi;
    it.pt = rnd_value();
    req_q = {req_q, it};
    end_pool = {end_pool, lo};
    end_pool = {end_pool, hi};
    while (end_pool.size() > 96) void'(end_pool.pop_front());
  endfunction

  function automatic void add_query(input logic [FIELD_W-1:0] p);
    req_item_t it;
    it.cmd = CMD_QUERY;
    it.lo = rnd_value();
    it.hi = rnd_value();
    it.pt = p;
    req_q = {req_q, it};
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : drive_req
    req_item_t nxt;
    answer_t   ans;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) begin
        ans.hit = 1'b0;
        ans.status = ST_OK;
        if (cmd == CMD_INSERT) ans.status = merge_range(range_low, range_high);
        else ans.hit = covers(probe);
        ans.total = union_size;
        answer_q = {answer_q, ans};
        items_sent <= items_sent + 1;
      end
      if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
        nxt = req_q.pop_front();
        req_valid <= 1'b1;
        cmd <= nxt.cmd;
        range_low <= nxt.lo;
        range_high <= nxt.hi;
        probe <= nxt.pt;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_rsp
    answer_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          log_failure("Response arrived with no answer expected.");
        end else begin
          want = answer_q.pop_front();
          if (hit !== want.hit || covered_total !== want.total || status !== want.status) begin
            log_failure($sformatf(
                "Mismatch: hit exp %0b got %0b, total exp %0d got %0d, status exp %0d got %0d",
                want.hit, hit, want.total, covered_total, want.status, status));
          end
        end
      end
      rsp_ready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  initial begin
    logic [FIELD_W-1:0] base, a, b, e;
    int                 slot[70];
    int                 j, t, r, len;

    add_query('0);
    add_insert('0, '0);
    add_query('0);
    add_query(VMAX);
    add_insert(VMAX, VMAX);
    add_query(VMAX);
    add_insert(2, 4);
    add_insert(1, 1);
    add_query(4);
    add_query(5);
    add_insert(7, 6);
    add_insert(VMAX, '0);
    add_insert(VMAX - 3, VMAX - 1);
    add_query(VMAX - 4);
    add_insert(10, 20);
    add_insert(12, 15);
    add_insert(5, 9);
    add_insert(21, 21);
    add_insert(100, 200);
    add_insert(300, 400);
    add_insert(150, 350);
    add_query(250);
    add_query(99);
    add_query(63'h2AAA_AAAA_AAAA_AAAA);
    add_query(63'h5555_5555_5555_5555);

    // Each round packs a fresh window with disjoint ranges in shuffled order so the
    // table fills up, then works on that window with touches, spans and lookups.
    for (int rnd = 0; rnd < 5; rnd++) begin
      base = rnd_value();
      if (base > VMAX - 63'd1048576) base = base - 63'd1048576;
      for (int s = 0; s < 70; s++) slot[s] = s;
      for (int s = 69; s > 0; s--) begin
        j = $urandom_range(0, s);
        t = slot[s];
        slot[s] = slot[j];
        slot[j] = t;
      end
      for (int s = 0; s < 70; s++) begin
        a = base + FIELD_W'(10 * slot[s]);
        add_insert(a, a + FIELD_W'($urandom_range(0, 7)));
      end
      for (int s = 0; s < 120; s++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          t = $urandom_range(0, 99);
          if (t < 60) add_query(pick_end() + FIELD_W'($urandom_range(0, 2)) - 63'd1);
          else if (t < 85) add_query(base + FIELD_W'($urandom_range(0, 800)));
          else add_query(rnd_value());
        end else if (r < 60) begin
          a = base + FIELD_W'($urandom_range(0, 800));
          add_insert(a, a + FIELD_W'($urandom_range(0, 6)));
        end else if (r < 72) begin
          e = pick_end();
          len = $urandom_range(0, 5);
          if ($urandom_range(0, 1) == 1 || e < FIELD_W'(len + 1))
            add_insert(e + 63'd1, e + 63'd1 + FIELD_W'(len));
          else
            add_insert(e - 63'd1 - FIELD_W'(len), e - 63'd1);
        end else if (r < 82) begin
          a = pick_end();
          b = pick_end();
          if (a > b) add_insert(b, a);
          else add_insert(a, b);
        end else if (r < 88) begin
          b = rnd_value();
          add_insert(b + FIELD_W'($urandom_range(1, 1000)), b);
        end else if (r < 92) begin
          a = rnd_value();
          b = rnd_value();
          if (a > b) add_insert(b, a);
          else add_insert(a, b);
        end else begin
          len = $urandom_range(0, 50);
          if ($urandom_range(0, 1) == 1) add_insert('0, FIELD_W'(len));
          else add_insert(VMAX - FIELD_W'(len), VMAX);
        end
      end
    end

    // Cover the whole value space last so the covered total saturates.
    add_insert(1, VMAX - 1);
    add_query('0);
    add_insert('0, VMAX);
    add_query(VMAX);
    add_insert(9, 3);
    items_total = req_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (items_sent < items_total || answer_q.size() != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
